>>> hdl/cau_pkg.sv
// Shared operation codes and pipeline control word for the complex arithmetic unit
`timescale 1ns / 1ps
package cau_pkg;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_SCL = 3'd4,
		OP_CMP = 3'd5
	} op_t;

	typedef struct packed {
		logic valid;
		logic is_div;
		logic zero_out;
		logic equal;
		logic div_zero;
		logic neg_re;
		logic neg_im;
		logic big_re;
		logic big_im;
	} ctrl_t;

endpackage

>>> hdl/complex_arithmetic_unit.sv
// Top level of the pipelined complex fixed-point arithmetic unit
`timescale 1ns / 1ps
// Accepts one word per cycle on start, with busy held low. done rises once the
// word has passed the operand, product, sum and setup stages, every divider step
// and the output register. EW is DATA_WIDTH capped at 32. The depth comes from
// the restoring divider, which makes one quotient bit per stage. Every word walks
// through the divider, so results leave in order. The receiver cannot stall the
// unit, so each result is shown for one cycle only.
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [31:0] a_re,
	input  logic [31:0] a_im,
	input  logic [31:0] b_re,
	input  logic [31:0] b_im,
	output logic        done,
	output logic [31:0] res_re,
	output logic [31:0] res_im,
	output logic        equal,
	output logic        overflow,
	output logic        div_zero
);

	localparam int EW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
	localparam int FB = (FRAC_BITS > 31) ? 31 : FRAC_BITS;
	localparam int PW = 2 * EW;
	localparam int SW = 2 * EW + 2;
	localparam int RW = 3 * EW + FB + 1;

	// stage 1: operands
	logic                 v_s1;
	logic [2:0]           op_s1;
	logic signed [EW-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	// stage 2: products and short sums
	logic                 v_s2;
	logic [2:0]           op_s2;
	logic signed [EW:0]   sr_s2, si_s2;
	logic signed [PW-1:0] prr_s2, pii_s2, pri_s2, pir_s2, pbr_s2, pbi_s2;
	logic                 eq_s2;

	// stage 3: full sums and denominator
	logic                 v_s3;
	logic [2:0]           op_s3;
	logic signed [SW-1:0] vr_s3, vi_s3;
	logic [PW-1:0]        den_s3;
	logic                 eq_s3;

	logic signed [SW-1:0] vr_nxt, vi_nxt;

	// divider chain, index 0 is stage 4
	cau_pkg::ctrl_t ctrl_d   [0:EW];
	logic [PW-1:0]  den_d    [0:EW];
	logic [RW-1:0]  rem_re_d [0:EW];
	logic [RW-1:0]  rem_im_d [0:EW];
	logic [EW-1:0]  q_re_d   [0:EW];
	logic [EW-1:0]  q_im_d   [0:EW];

	cau_pkg::ctrl_t ctrl_s4, ctrl_nxt;
	logic [PW-1:0]  den_s4;
	logic [RW-1:0]  rem_re_s4, rem_im_s4, rem_re_nxt, rem_im_nxt;

	logic           done_q, eq_q, ovf_q, dz_q;
	logic [31:0]    res_re_q, res_im_q;
	logic [31:0]    fin_re, fin_im;
	logic           ovf_re, ovf_im;

	assign busy = 1'b0;

	function automatic logic [RW-1:0] div_prep(input logic signed [SW-1:0] v, output logic neg);
		logic [SW-1:0] mag;
		neg = v[SW-1];
		mag = neg ? SW'(-v) : SW'(v);
		return {{(RW-SW){1'b0}}, mag} << FB;
	endfunction

	function automatic logic [31:0] sat_out(input logic signed [RW-1:0] v, output logic ovf);
		logic signed [RW-1:0] maxv, minv;
		logic signed [EW-1:0] t;
		maxv = RW'(signed'({1'b0, {(EW-1){1'b1}}}));
		minv = RW'(signed'({1'b1, {(EW-1){1'b0}}}));
		ovf  = 1'b0;
		if (v > maxv) begin
			t   = maxv[EW-1:0];
			ovf = 1'b1;
		end else if (v < minv) begin
			t   = minv[EW-1:0];
			ovf = 1'b1;
		end else begin
			t = v[EW-1:0];
		end
		return 32'(t);
	endfunction

	function automatic logic signed [RW-1:0] div_value(input logic [EW-1:0] q, input logic big,
			input logic neg);
		logic [EW:0] qf;
		qf = big ? {1'b1, {EW{1'b0}}} : {1'b0, q};
		return neg ? -$signed({{(RW-EW-1){1'b0}}, qf}) : $signed({{(RW-EW-1){1'b0}}, qf});
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			ctrl_s4 <= '0;
			done_q  <= 1'b0;
		end else begin
			v_s1    <= start && !busy;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			ctrl_s4 <= ctrl_nxt;
			done_q  <= ctrl_d[EW].valid;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= op;
		ar_s1  <= a_re[EW-1:0];
		ai_s1  <= a_im[EW-1:0];
		br_s1  <= b_re[EW-1:0];
		bi_s1  <= b_im[EW-1:0];

		op_s2  <= op_s1;
		sr_s2  <= (op_s1 == cau_pkg::OP_SUB) ? (EW+1)'(ar_s1) - (EW+1)'(br_s1)
			: (EW+1)'(ar_s1) + (EW+1)'(br_s1);
		si_s2  <= (op_s1 == cau_pkg::OP_SUB) ? (EW+1)'(ai_s1) - (EW+1)'(bi_s1)
			: (EW+1)'(ai_s1) + (EW+1)'(bi_s1);
		prr_s2 <= PW'(ar_s1) * PW'(br_s1);
		pii_s2 <= PW'(ai_s1) * PW'(bi_s1);
		pri_s2 <= PW'(ar_s1) * PW'(bi_s1);
		pir_s2 <= PW'(ai_s1) * PW'(br_s1);
		pbr_s2 <= PW'(br_s1) * PW'(br_s1);
		pbi_s2 <= PW'(bi_s1) * PW'(bi_s1);
		eq_s2  <= (ar_s1 == br_s1) && (ai_s1 == bi_s1);

		op_s3  <= op_s2;
		vr_s3  <= vr_nxt;
		vi_s3  <= vi_nxt;
		den_s3 <= pbr_s2 + pbi_s2;
		eq_s3  <= eq_s2;

		den_s4    <= den_s3;
		rem_re_s4 <= rem_re_nxt;
		rem_im_s4 <= rem_im_nxt;

		res_re_q <= fin_re;
		res_im_q <= fin_im;
		eq_q     <= ctrl_d[EW].equal;
		dz_q     <= ctrl_d[EW].div_zero;
		ovf_q    <= !ctrl_d[EW].zero_out && (ovf_re || ovf_im);
	end

	always_comb begin
		case (cau_pkg::op_t'(op_s2))
			cau_pkg::OP_MUL: begin
				vr_nxt = SW'(prr_s2) - SW'(pii_s2);
				vi_nxt = SW'(pri_s2) + SW'(pir_s2);
			end
			cau_pkg::OP_DIV: begin
				vr_nxt = SW'(prr_s2) + SW'(pii_s2);
				vi_nxt = SW'(pir_s2) - SW'(pri_s2);
			end
			cau_pkg::OP_SCL: begin
				vr_nxt = SW'(prr_s2);
				vi_nxt = SW'(pir_s2);
			end
			default: begin
				vr_nxt = SW'(sr_s2);
				vi_nxt = SW'(si_s2);
			end
		endcase
	end

	// stage 4: shift products back to the fraction point, set up the dividends, or flag compare and zero results
	always_comb begin
		logic [RW-1:0] dsh;
		dsh      = {{(RW-PW){1'b0}}, den_s3} << EW;
		ctrl_nxt = '0;
		ctrl_nxt.valid = v_s3;
		rem_re_nxt = RW'(vr_s3);
		rem_im_nxt = RW'(vi_s3);
		case (cau_pkg::op_t'(op_s3))
			cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
			end
			cau_pkg::OP_MUL, cau_pkg::OP_SCL: begin
				rem_re_nxt = RW'(vr_s3 >>> FB);
				rem_im_nxt = RW'(vi_s3 >>> FB);
			end
			cau_pkg::OP_DIV: begin
				if (den_s3 == '0) begin
					ctrl_nxt.zero_out = 1'b1;
					ctrl_nxt.div_zero = 1'b1;
				end else begin
					ctrl_nxt.is_div = 1'b1;
				end
				rem_re_nxt = div_prep(vr_s3, ctrl_nxt.neg_re);
				rem_im_nxt = div_prep(vi_s3, ctrl_nxt.neg_im);
				ctrl_nxt.big_re = rem_re_nxt >= dsh;
				ctrl_nxt.big_im = rem_im_nxt >= dsh;
			end
			cau_pkg::OP_CMP: begin
				ctrl_nxt.zero_out = 1'b1;
				ctrl_nxt.equal    = eq_s3;
			end
			default: begin
				ctrl_nxt.zero_out = 1'b1;
			end
		endcase
	end

	assign ctrl_d[0]   = ctrl_s4;
	assign den_d[0]    = den_s4;
	assign rem_re_d[0] = rem_re_s4;
	assign rem_im_d[0] = rem_im_s4;
	assign q_re_d[0]   = '0;
	assign q_im_d[0]   = '0;

	for (genvar i = 0; i < EW; i++) begin : g_div
		cau_div_step #(
			.RW    (RW),
			.DW    (PW),
			.QW    (EW),
			.SHIFT (EW - 1 - i)
		) u_step (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl_in    (ctrl_d[i]),
			.den_in     (den_d[i]),
			.rem_re_in  (rem_re_d[i]),
			.rem_im_in  (rem_im_d[i]),
			.q_re_in    (q_re_d[i]),
			.q_im_in    (q_im_d[i]),
			.ctrl_out   (ctrl_d[i+1]),
			.den_out    (den_d[i+1]),
			.rem_re_out (rem_re_d[i+1]),
			.rem_im_out (rem_im_d[i+1]),
			.q_re_out   (q_re_d[i+1]),
			.q_im_out   (q_im_d[i+1])
		);
	end

	// last stage: pick quotient or passed value, saturate, drop for zero results
	always_comb begin
		logic signed [RW-1:0] vr, vi;
		if (ctrl_d[EW].is_div) begin
			vr = div_value(q_re_d[EW], ctrl_d[EW].big_re, ctrl_d[EW].neg_re);
			vi = div_value(q_im_d[EW], ctrl_d[EW].big_im, ctrl_d[EW].neg_im);
		end else begin
			vr = $signed(rem_re_d[EW]);
			vi = $signed(rem_im_d[EW]);
		end
		fin_re = sat_out(vr, ovf_re);
		fin_im = sat_out(vi, ovf_im);
		if (ctrl_d[EW].zero_out) begin
			fin_re = '0;
			fin_im = '0;
		end
	end

	assign done     = done_q;
	assign res_re   = res_re_q;
	assign res_im   = res_im_q;
	assign equal    = eq_q;
	assign overflow = ovf_q;
	assign div_zero = dz_q;

endmodule

>>> hdl/cau_div_step.sv
// One restoring-division step for both result parts, registered
`timescale 1ns / 1ps
module cau_div_step #(
	parameter int RW    = 97,
	parameter int DW    = 64,
	parameter int QW    = 32,
	parameter int SHIFT = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cau_pkg::ctrl_t ctrl_in,
	input  logic [DW-1:0]  den_in,
	input  logic [RW-1:0]  rem_re_in,
	input  logic [RW-1:0]  rem_im_in,
	input  logic [QW-1:0]  q_re_in,
	input  logic [QW-1:0]  q_im_in,
	output cau_pkg::ctrl_t ctrl_out,
	output logic [DW-1:0]  den_out,
	output logic [RW-1:0]  rem_re_out,
	output logic [RW-1:0]  rem_im_out,
	output logic [QW-1:0]  q_re_out,
	output logic [QW-1:0]  q_im_out
);

	logic [RW-1:0] dsh;
	logic          take_re, take_im;
	logic [RW-1:0] rem_re_nxt, rem_im_nxt;

	cau_pkg::ctrl_t ctrl_q;
	logic [DW-1:0]  den_q;
	logic [RW-1:0]  rem_re_q, rem_im_q;
	logic [QW-1:0]  q_re_q, q_im_q;

	assign dsh = {{(RW-DW){1'b0}}, den_in} << SHIFT;

	always_comb begin
		take_re    = ctrl_in.is_div && (rem_re_in >= dsh);
		take_im    = ctrl_in.is_div && (rem_im_in >= dsh);
		rem_re_nxt = take_re ? rem_re_in - dsh : rem_re_in;
		rem_im_nxt = take_im ? rem_im_in - dsh : rem_im_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else begin
			ctrl_q <= ctrl_in;
		end
	end

	// non-divide words ride through in the remainder field untouched
	always_ff @(posedge clk) begin
		den_q    <= den_in;
		rem_re_q <= rem_re_nxt;
		rem_im_q <= rem_im_nxt;
		q_re_q   <= {q_re_in[QW-2:0], take_re};
		q_im_q   <= {q_im_in[QW-2:0], take_im};
	end

	assign ctrl_out   = ctrl_q;
	assign den_out    = den_q;
	assign rem_re_out = rem_re_q;
	assign rem_im_out = rem_im_q;
	assign q_re_out   = q_re_q;
	assign q_im_out   = q_im_q;

endmodule
